// ===== design/cose_pkg.sv =====
`timescale 1ns / 1ps

package cose_pkg;

  // Operation class picked by the front end from the opcode byte.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LD_BC_NN,
    OP_ST_A_BC,
    OP_INC_BC,
    OP_INC_B,
    OP_DEC_B,
    OP_LD_B_N,
    OP_RLCA,
    OP_ST_SP_NN,
    OP_ADD_HL_BC,
    OP_LD_A_BC,
    OP_DEC_BC,
    OP_INC_C,
    OP_DEC_C,
    OP_LD_C_N,
    OP_RRCA,
    OP_UNHANDLED
  } cose_op_e;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_BYTE = 2'd1,
    WR_WORD = 2'd2
  } cose_wkind_e;

  // One classified instruction as it waits between front and back end.
  typedef struct packed {
    cose_op_e    op;
    logic [1:0]  len;
    logic [15:0] imm;
    logic [7:0]  load_data;
  } cose_entry_t;

  localparam logic [15:0] PcReset = 16'h0100;
  localparam logic [15:0] SpReset = 16'hFFFE;

  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

endpackage

// ===== design/cose_if.sv =====
`timescale 1ns / 1ps

interface cose_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] imm_low;
  logic [7:0] imm_high;
  logic [7:0] load_data;

  modport source (output valid, output opcode, output imm_low, output imm_high,
                  output load_data, input ready);
  modport sink (input valid, input opcode, input imm_low, input imm_high,
                input load_data, output ready);
endinterface

interface cose_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [7:0]  reg_a;
  logic [15:0] reg_bc;
  logic [15:0] reg_hl;
  logic [3:0]  flag_bits;
  logic [1:0]  write_kind;
  logic [15:0] write_address;
  logic [15:0] write_data;
  logic        unhandled;

  modport source (output valid, output next_pc, output reg_a, output reg_bc,
                  output reg_hl, output flag_bits, output write_kind,
                  output write_address, output write_data, output unhandled,
                  input ready);
  modport sink (input valid, input next_pc, input reg_a, input reg_bc,
                input reg_hl, input flag_bits, input write_kind,
                input write_address, input write_data, input unhandled,
                output ready);
endinterface

// ===== design/cose_front.sv =====
`timescale 1ns / 1ps

module cose_front (
  cose_in_if.sink              in_i,
  output logic                 push_valid_o,
  output cose_pkg::cose_entry_t push_entry_o,
  input  logic                 push_ready_i
);
  import cose_pkg::*;

  localparam logic [7:0] OpcNop     = 8'h00;
  localparam logic [7:0] OpcLdBcNn  = 8'h01;
  localparam logic [7:0] OpcStABc   = 8'h02;
  localparam logic [7:0] OpcIncBc   = 8'h03;
  localparam logic [7:0] OpcIncB    = 8'h04;
  localparam logic [7:0] OpcDecB    = 8'h05;
  localparam logic [7:0] OpcLdBN    = 8'h06;
  localparam logic [7:0] OpcRlca    = 8'h07;
  localparam logic [7:0] OpcStSpNn  = 8'h08;
  localparam logic [7:0] OpcAddHlBc = 8'h09;
  localparam logic [7:0] OpcLdABc   = 8'h0A;
  localparam logic [7:0] OpcDecBc   = 8'h0B;
  localparam logic [7:0] OpcIncC    = 8'h0C;
  localparam logic [7:0] OpcDecC    = 8'h0D;
  localparam logic [7:0] OpcLdCN    = 8'h0E;
  localparam logic [7:0] OpcRrca    = 8'h0F;

  cose_op_e   op;
  logic [1:0] len;

  always_comb begin
    len = 2'd1;
    unique case (in_i.opcode)
      OpcNop:     op = OP_NOP;
      OpcLdBcNn: begin
        op  = OP_LD_BC_NN;
        len = 2'd3;
      end
      OpcStABc:   op = OP_ST_A_BC;
      OpcIncBc:   op = OP_INC_BC;
      OpcIncB:    op = OP_INC_B;
      OpcDecB:    op = OP_DEC_B;
      OpcLdBN: begin
        op  = OP_LD_B_N;
        len = 2'd2;
      end
      OpcRlca:    op = OP_RLCA;
      OpcStSpNn: begin
        op  = OP_ST_SP_NN;
        len = 2'd3;
      end
      OpcAddHlBc: op = OP_ADD_HL_BC;
      OpcLdABc:   op = OP_LD_A_BC;
      OpcDecBc:   op = OP_DEC_BC;
      OpcIncC:    op = OP_INC_C;
      OpcDecC:    op = OP_DEC_C;
      OpcLdCN: begin
        op  = OP_LD_C_N;
        len = 2'd2;
      end
      OpcRrca:    op = OP_RRCA;
      default:    op = OP_UNHANDLED;
    endcase
  end

  assign push_valid_o           = in_i.valid;
  assign in_i.ready             = push_ready_i;
  assign push_entry_o.op        = op;
  assign push_entry_o.len       = len;
  assign push_entry_o.imm       = {in_i.imm_high, in_i.imm_low};
  assign push_entry_o.load_data = in_i.load_data;

endmodule

// ===== design/cose_queue.sv =====
`timescale 1ns / 1ps

module cose_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  input  cose_pkg::cose_entry_t push_entry_i,
  output logic                  push_ready_o,
  output logic                  head_valid_o,
  output cose_pkg::cose_entry_t head_entry_o,
  input  logic                  pop_i
);
  import cose_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cose_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != CntFull);
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== design/cose_back.sv =====
`timescale 1ns / 1ps

module cose_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_en_i,
  input  logic [15:0]           cfg_wr_data_i,
  input  logic                  head_valid_i,
  input  cose_pkg::cose_entry_t head_entry_i,
  output logic                  pop_o,
  cose_out_if.source            out_o
);
  import cose_pkg::*;

  logic [15:0] sp_q;
  logic [15:0] pc_q, pc_d;
  logic [7:0]  a_q, a_d, b_q, b_d, c_q, c_d, h_q, h_d, l_q, l_d;
  logic [3:0]  flags_q, flags_d;
  logic        out_valid_q;

  logic [15:0] bc, hl;
  logic [16:0] sum;
  logic [12:0] half_sum;
  logic [7:0]  b_inc, b_dec, c_inc, c_dec;
  cose_wkind_e wkind;
  logic [15:0] waddr, wdata;
  logic        unh;

  logic [15:0] res_pc_q, res_bc_q, res_hl_q, res_waddr_q, res_wdata_q;
  logic [7:0]  res_a_q;
  logic [3:0]  res_flags_q;
  cose_wkind_e res_wkind_q;
  logic        res_unh_q;

  // Z, N, H, C after an 8-bit increment or decrement; carry is kept.
  function automatic logic [3:0] inc_flags(input logic [7:0] v, input logic c);
    return {v == 8'h00, 1'b0, v[3:0] == 4'h0, c};
  endfunction

  function automatic logic [3:0] dec_flags(input logic [7:0] v, input logic c);
    return {v == 8'h00, 1'b1, v[3:0] == 4'hF, c};
  endfunction

  // The output register is free when empty or being drained this cycle.
  assign pop_o = head_valid_i && (!out_valid_q || out_o.ready);

  assign bc       = {b_q, c_q};
  assign hl       = {h_q, l_q};
  assign sum      = {1'b0, hl} + {1'b0, bc};
  assign half_sum = {1'b0, hl[11:0]} + {1'b0, bc[11:0]};
  assign b_inc    = b_q + 8'd1;
  assign b_dec    = b_q - 8'd1;
  assign c_inc    = c_q + 8'd1;
  assign c_dec    = c_q - 8'd1;

  always_comb begin
    pc_d    = pc_q + {14'b0, head_entry_i.len};
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    h_d     = h_q;
    l_d     = l_q;
    flags_d = flags_q;
    wkind   = WR_NONE;
    waddr   = '0;
    wdata   = '0;
    unh     = 1'b0;
    unique case (head_entry_i.op)
      OP_NOP: begin
      end
      OP_LD_BC_NN: begin
        b_d = head_entry_i.imm[15:8];
        c_d = head_entry_i.imm[7:0];
      end
      OP_ST_A_BC: begin
        wkind = WR_BYTE;
        waddr = bc;
        wdata = {8'h00, a_q};
      end
      OP_INC_BC:   {b_d, c_d} = bc + 16'd1;
      OP_DEC_BC:   {b_d, c_d} = bc - 16'd1;
      OP_INC_B: begin
        b_d     = b_inc;
        flags_d = inc_flags(b_inc, flags_q[FlagC]);
      end
      OP_DEC_B: begin
        b_d     = b_dec;
        flags_d = dec_flags(b_dec, flags_q[FlagC]);
      end
      OP_INC_C: begin
        c_d     = c_inc;
        flags_d = inc_flags(c_inc, flags_q[FlagC]);
      end
      OP_DEC_C: begin
        c_d     = c_dec;
        flags_d = dec_flags(c_dec, flags_q[FlagC]);
      end
      OP_LD_B_N:   b_d = head_entry_i.imm[7:0];
      OP_LD_C_N:   c_d = head_entry_i.imm[7:0];
      OP_RLCA: begin
        a_d     = {a_q[6:0], a_q[7]};
        flags_d = {3'b000, a_q[7]};
      end
      OP_RRCA: begin
        a_d     = {a_q[0], a_q[7:1]};
        flags_d = {3'b000, a_q[0]};
      end
      OP_ST_SP_NN: begin
        wkind = WR_WORD;
        waddr = head_entry_i.imm;
        wdata = sp_q;
      end
      OP_ADD_HL_BC: begin
        {h_d, l_d}     = sum[15:0];
        flags_d        = '0;
        flags_d[FlagZ] = flags_q[FlagZ];
        flags_d[FlagH] = half_sum[12];
        flags_d[FlagC] = sum[16];
      end
      OP_LD_A_BC:  a_d = head_entry_i.load_data;
      OP_UNHANDLED: unh = 1'b1;
      default:      unh = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= SpReset;
      pc_q        <= PcReset;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      h_q         <= '0;
      l_q         <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        sp_q <= cfg_wr_data_i;
      end
      if (pop_o) begin
        pc_q    <= pc_d;
        a_q     <= a_d;
        b_q     <= b_d;
        c_q     <= c_d;
        h_q     <= h_d;
        l_q     <= l_d;
        flags_q <= flags_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_pc_q    <= pc_d;
      res_a_q     <= a_d;
      res_bc_q    <= {b_d, c_d};
      res_hl_q    <= {h_d, l_d};
      res_flags_q <= flags_d;
      res_wkind_q <= wkind;
      res_waddr_q <= waddr;
      res_wdata_q <= wdata;
      res_unh_q   <= unh;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.next_pc       = res_pc_q;
  assign out_o.reg_a         = res_a_q;
  assign out_o.reg_bc        = res_bc_q;
  assign out_o.reg_hl        = res_hl_q;
  assign out_o.flag_bits     = res_flags_q;
  assign out_o.write_kind    = res_wkind_q;
  assign out_o.write_address = res_waddr_q;
  assign out_o.write_data    = res_wdata_q;
  assign out_o.unhandled     = res_unh_q;

endmodule

// ===== design/cpu_opcode_subset_exec.sv =====
`timescale 1ns / 1ps
// Instruction executor for opcodes 0x00 to 0x0F of a small 8-bit CPU.
// in_i carries one instruction per beat: opcode, two immediate bytes (low
// byte first) and the byte found at address BC. out_o returns one beat per
// instruction: next PC, A, BC, HL, flags, the memory write it makes and an
// unhandled mark for opcodes outside the set.
// The stack pointer stored by LD (nn),SP is written via cfg_wr_en_i and
// cfg_wr_data_i; the user must do so only while no instruction is in flight
// (the block does not enforce this). A front end classifies each instruction
// and places it in a short queue; the back end executes one instruction per
// cycle from the queue head into an output register while the receiver does
// not stall. A result passes through the queue and then the output register
// before it is offered on out_o.
// If the receiver stalls, the output register holds its beat, the queue
// fills with up to QueueDepth instructions and then in_i.ready drops.
// Reset sets PC to 0x0100, the stack pointer to 0xFFFE, and A, B, C, H, L
// and the flags to zero; the queue and output register are emptied.
module cpu_opcode_subset_exec #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cose_in_if.sink     in_i,
  cose_out_if.source  out_o,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i
);
  import cose_pkg::*;

  logic        push_valid, push_ready;
  cose_entry_t push_entry;
  logic        head_valid, pop;
  cose_entry_t head_entry;

  cose_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  cose_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry),
    .pop_i        (pop)
  );

  cose_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .head_valid_i  (head_valid),
    .head_entry_i  (head_entry),
    .pop_o         (pop),
    .out_o         (out_o)
  );

endmodule

// ===== design/cose_checker.sv =====
`timescale 1ns / 1ps

module cose_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  write_kind_i,
  input logic [15:0] write_address_i,
  input logic [15:0] write_data_i,
  input logic        unhandled_i
);
  import cose_pkg::*;

  // A result beat stays offered until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // An output register that was empty only fills from an accepted beat, which
  // passes through the queue first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without an accepted instruction");

  // Unhandled opcodes never write memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unhandled_i |->
      write_kind_i == WR_NONE && write_address_i == 16'h0000 &&
      write_data_i == 16'h0000)
    else $error("unhandled opcode produced a write");

  // Only the three write kinds occur, and a byte write has a clean high byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> write_kind_i != 2'd3 &&
      (write_kind_i != WR_BYTE || write_data_i[15:8] == 8'h00))
    else $error("malformed write in result");

endmodule

bind cpu_opcode_subset_exec cose_checker u_cose_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .write_kind_i    (out_o.write_kind),
  .write_address_i (out_o.write_address),
  .write_data_i    (out_o.write_data),
  .unhandled_i     (out_o.unhandled)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cose_pkg::*;

  localparam logic [7:0] OPC_NOP       = 8'h00;
  localparam logic [7:0] OPC_LD_BC_NN  = 8'h01;
  localparam logic [7:0] OPC_ST_A_BC   = 8'h02;
  localparam logic [7:0] OPC_INC_BC    = 8'h03;
  localparam logic [7:0] OPC_INC_B     = 8'h04;
  localparam logic [7:0] OPC_DEC_B     = 8'h05;
  localparam logic [7:0] OPC_LD_B_N    = 8'h06;
  localparam logic [7:0] OPC_RLCA      = 8'h07;
  localparam logic [7:0] OPC_ST_SP_NN  = 8'h08;
  localparam logic [7:0] OPC_ADD_HL_BC = 8'h09;
  localparam logic [7:0] OPC_LD_A_BC   = 8'h0A;
  localparam logic [7:0] OPC_DEC_BC    = 8'h0B;
  localparam logic [7:0] OPC_INC_C     = 8'h0C;
  localparam logic [7:0] OPC_DEC_C     = 8'h0D;
  localparam logic [7:0] OPC_LD_C_N    = 8'h0E;
  localparam logic [7:0] OPC_RRCA      = 8'h0F;
  localparam logic [7:0] OPC_LAST      = 8'hFF;

  localparam int unsigned IdlePercent = 38;
  localparam int unsigned CycleLimit  = 1000000;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] load_data;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [7:0]  reg_a;
    logic [15:0] reg_bc;
    logic [15:0] reg_hl;
    logic [3:0]  flag_bits;
    cose_wkind_e write_kind;
    logic [15:0] write_address;
    logic [15:0] write_data;
    logic        unhandled;
  } exec_result_t;

  typedef enum logic [1:0] {
    ENTRY_INSTR,
    ENTRY_SP_WRITE,
    ENTRY_DRAIN
  } entry_kind_e;

  typedef struct packed {
    entry_kind_e kind;
    instr_t      instr;
    logic [15:0] sp_value;
  } prog_entry_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  cose_in_if  in_bus ();
  cose_out_if out_bus ();

  cpu_opcode_subset_exec uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_bus),
    .out_o        (out_bus),
    .cfg_wr_en_i  (cfg_wr_en),
    .cfg_wr_data_i(cfg_wr_data)
  );

  // Architectural state as the testbench expects it to evolve.
  logic [15:0] cpu_pc    = PcReset;
  logic [15:0] cpu_sp    = SpReset;
  logic [7:0]  cpu_a     = '0;
  logic [7:0]  cpu_b     = '0;
  logic [7:0]  cpu_c     = '0;
  logic [7:0]  cpu_h     = '0;
  logic [7:0]  cpu_l     = '0;
  logic [3:0]  cpu_flags = '0;

  prog_entry_t  program_queue[$];
  exec_result_t pending_results[$];

  logic in_taken;
  int   quiet_cycles;
  int   items_accepted;
  int   beats_checked;
  int   unhandled_seen;
  int   sp_writes;
  int   error_count;
  int   cycle_count;

  // Both sides run without idling while this window is open.
  wire calm = (items_accepted >= 150) && (items_accepted < 300);

  function automatic logic [1:0] instr_length(input logic [7:0] opcode);
    case (opcode)
      OPC_LD_BC_NN, OPC_ST_SP_NN: return 2'd3;
      OPC_LD_B_N, OPC_LD_C_N:     return 2'd2;
      default:                    return 2'd1;
    endcase
  endfunction

  function automatic logic [3:0] step_flags(input logic [7:0] value, input logic is_dec);
    logic [3:0] f;
    f         = '0;
    f[FlagC]  = cpu_flags[FlagC];
    f[FlagN]  = is_dec;
    f[FlagZ]  = (value == 8'h00);
    f[FlagH]  = is_dec ? (value[3:0] == 4'hF) : (value[3:0] == 4'h0);
    return f;
  endfunction

  function automatic exec_result_t execute_instr(input instr_t ins);
    exec_result_t r;
    logic [15:0]  bc;
    logic [15:0]  hl;
    logic [16:0]  sum;
    logic [12:0]  low_sum;
    bc = {cpu_b, cpu_c};
    hl = {cpu_h, cpu_l};
    r = '0;
    r.write_kind = WR_NONE;
    case (ins.opcode)
      OPC_NOP: ;
      OPC_LD_BC_NN: {cpu_b, cpu_c} = {ins.imm_high, ins.imm_low};
      OPC_ST_A_BC: begin
        r.write_kind    = WR_BYTE;
        r.write_address = bc;
        r.write_data    = {8'h00, cpu_a};
      end
      OPC_INC_BC: {cpu_b, cpu_c} = bc + 16'd1;
      OPC_INC_B: begin
        cpu_b     = cpu_b + 8'd1;
        cpu_flags = step_flags(cpu_b, 1'b0);
      end
      OPC_DEC_B: begin
        cpu_b     = cpu_b - 8'd1;
        cpu_flags = step_flags(cpu_b, 1'b1);
      end
      OPC_LD_B_N: cpu_b = ins.imm_low;
      OPC_RLCA: begin
        cpu_flags        = '0;
        cpu_flags[FlagC] = cpu_a[7];
        cpu_a            = {cpu_a[6:0], cpu_a[7]};
      end
      OPC_ST_SP_NN: begin
        r.write_kind    = WR_WORD;
        r.write_address = {ins.imm_high, ins.imm_low};
        r.write_data    = cpu_sp;
      end
      OPC_ADD_HL_BC: begin
        sum     = {1'b0, hl} + {1'b0, bc};
        low_sum = {1'b0, hl[11:0]} + {1'b0, bc[11:0]};
        cpu_flags[FlagN] = 1'b0;
        cpu_flags[FlagC] = sum[16];
        cpu_flags[FlagH] = low_sum[12];
        {cpu_h, cpu_l}   = sum[15:0];
      end
      OPC_LD_A_BC: cpu_a = ins.load_data;
      OPC_DEC_BC: {cpu_b, cpu_c} = bc - 16'd1;
      OPC_INC_C: begin
        cpu_c     = cpu_c + 8'd1;
        cpu_flags = step_flags(cpu_c, 1'b0);
      end
      OPC_DEC_C: begin
        cpu_c     = cpu_c - 8'd1;
        cpu_flags = step_flags(cpu_c, 1'b1);
      end
      OPC_LD_C_N: cpu_c = ins.imm_low;
      OPC_RRCA: begin
        cpu_flags        = '0;
        cpu_flags[FlagC] = cpu_a[0];
        cpu_a            = {cpu_a[0], cpu_a[7:1]};
      end
      default: r.unhandled = 1'b1;
    endcase
    cpu_pc = cpu_pc + 16'(instr_length(ins.opcode));
    r.next_pc   = cpu_pc;
    r.reg_a     = cpu_a;
    r.reg_bc    = {cpu_b, cpu_c};
    r.reg_hl    = {cpu_h, cpu_l};
    r.flag_bits = cpu_flags;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic instr_t random_instr(input int unsigned unhandled_percent);
    instr_t ins;
    if ($urandom_range(99) < unhandled_percent)
      ins.opcode = 8'($urandom_range(OPC_LAST, OPC_RRCA + 1));
    else
      ins.opcode = 8'($urandom_range(OPC_RRCA, OPC_NOP));
    ins.imm_low   = random_byte();
    ins.imm_high  = random_byte();
    ins.load_data = random_byte();
    return ins;
  endfunction

  task automatic push_instr(input instr_t ins);
    prog_entry_t e;
    e = '0;
    e.kind  = ENTRY_INSTR;
    e.instr = ins;
    program_queue.push_back(e);
  endtask

  task automatic push_op(input logic [7:0] opcode, input logic [7:0] lo,
                         input logic [7:0] hi, input logic [7:0] ld);
    push_instr({opcode, lo, hi, ld});
  endtask

  task automatic push_sp_write(input logic [15:0] value);
    prog_entry_t e;
    e = '0;
    e.kind     = ENTRY_SP_WRITE;
    e.sp_value = value;
    program_queue.push_back(e);
  endtask

  task automatic push_drain();
    prog_entry_t e;
    e = '0;
    e.kind = ENTRY_DRAIN;
    program_queue.push_back(e);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: new values go out on the falling edge, one assignment per signal.
  always @(negedge clk) begin : driver
    logic        hold_valid;
    logic        load_next;
    logic        write_sp;
    prog_entry_t head;
    if (rst_n) begin
      hold_valid = in_bus.valid && !in_taken;
      load_next  = 1'b0;
      write_sp   = 1'b0;
      head       = '0;
      if (!hold_valid && pending_results.size() == 0) quiet_cycles++;
      else quiet_cycles = 0;
      if (!hold_valid && program_queue.size() != 0) begin
        head = program_queue[0];
        case (head.kind)
          ENTRY_INSTR: begin
            if (calm || $urandom_range(99) >= IdlePercent) begin
              load_next = 1'b1;
              void'(program_queue.pop_front());
            end
          end
          ENTRY_SP_WRITE: begin
            if (quiet_cycles >= 3) begin
              write_sp = 1'b1;
              sp_writes++;
              void'(program_queue.pop_front());
            end
          end
          default: begin
            if (quiet_cycles >= 3) void'(program_queue.pop_front());
          end
        endcase
      end
      if (load_next) begin
        in_bus.opcode    <= head.instr.opcode;
        in_bus.imm_low   <= head.instr.imm_low;
        in_bus.imm_high  <= head.instr.imm_high;
        in_bus.load_data <= head.instr.load_data;
      end
      if (write_sp) cfg_wr_data <= head.sp_value;
      in_bus.valid  <= hold_valid || load_next;
      cfg_wr_en     <= write_sp;
      out_bus.ready <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Predict on every accepted instruction and check every returned beat.
  always @(posedge clk or negedge rst_n) begin : scoreboard
    exec_result_t want;
    exec_result_t got;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_bus.valid && in_bus.ready;
      if (cfg_wr_en) cpu_sp = cfg_wr_data;
      if (in_bus.valid && in_bus.ready) begin
        pending_results.push_back(execute_instr({in_bus.opcode, in_bus.imm_low,
                                                 in_bus.imm_high, in_bus.load_data}));
        items_accepted++;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.next_pc       = out_bus.next_pc;
        got.reg_a         = out_bus.reg_a;
        got.reg_bc        = out_bus.reg_bc;
        got.reg_hl        = out_bus.reg_hl;
        got.flag_bits     = out_bus.flag_bits;
        got.write_kind    = cose_wkind_e'(out_bus.write_kind);
        got.write_address = out_bus.write_address;
        got.write_data    = out_bus.write_data;
        got.unhandled     = out_bus.unhandled;
        if (pending_results.size() == 0) begin
          $error("result beat arrived with no instruction outstanding");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          beats_checked++;
          if (want.unhandled) unhandled_seen++;
          check_field("next_pc", want.next_pc, got.next_pc);
          check_field("reg_a", 16'(want.reg_a), 16'(got.reg_a));
          check_field("reg_bc", want.reg_bc, got.reg_bc);
          check_field("reg_hl", want.reg_hl, got.reg_hl);
          check_field("flag_bits", 16'(want.flag_bits), 16'(got.flag_bits));
          check_field("write_kind", 16'(want.write_kind), 16'(got.write_kind));
          check_field("write_address", want.write_address, got.write_address);
          check_field("write_data", want.write_data, got.write_data);
          check_field("unhandled", 16'(want.unhandled), 16'(got.unhandled));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.opcode    = '0;
    in_bus.imm_low   = '0;
    in_bus.imm_high  = '0;
    in_bus.load_data = '0;
    out_bus.ready    = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;

    // Directed part: counter and flag boundaries, rotates, both write kinds,
    // a word write at the top of memory, and unimplemented opcodes.
    push_sp_write(16'hFFFF);
    push_op(OPC_NOP,       8'hFF, 8'hFF, 8'hFF);
    push_op(OPC_LD_BC_NN,  8'hFF, 8'hFF, 8'h00);
    push_op(OPC_INC_BC,    8'h00, 8'h00, 8'h00);
    push_op(OPC_DEC_BC,    8'h00, 8'h00, 8'h00);
    push_op(OPC_INC_C,     8'h00, 8'h00, 8'h00);
    push_op(OPC_DEC_C,     8'h00, 8'h00, 8'h00);
    push_op(OPC_INC_B,     8'h00, 8'h00, 8'h00);
    push_op(OPC_DEC_B,     8'h00, 8'h00, 8'h00);
    push_op(OPC_LD_B_N,    8'h0F, 8'hAA, 8'h00);
    push_op(OPC_INC_B,     8'h00, 8'h00, 8'h00);
    push_op(OPC_LD_C_N,    8'h01, 8'h55, 8'h00);
    push_op(OPC_DEC_C,     8'h00, 8'h00, 8'h00);
    push_op(OPC_LD_A_BC,   8'h00, 8'h00, 8'h80);
    push_op(OPC_RLCA,      8'h00, 8'h00, 8'h00);
    push_op(OPC_RRCA,      8'h00, 8'h00, 8'h00);
    push_op(OPC_ST_A_BC,   8'h00, 8'h00, 8'h00);
    push_op(OPC_ST_SP_NN,  8'hFF, 8'hFF, 8'h00);
    push_op(OPC_LD_BC_NN,  8'hFF, 8'h0F, 8'h00);
    push_op(OPC_ADD_HL_BC, 8'h00, 8'h00, 8'h00);
    push_op(OPC_ADD_HL_BC, 8'h00, 8'h00, 8'h00);
    push_op(OPC_LD_BC_NN,  8'h01, 8'hF0, 8'h00);
    push_op(OPC_ADD_HL_BC, 8'h00, 8'h00, 8'h00);
    push_op(OPC_LD_A_BC,   8'h00, 8'h00, 8'h00);
    push_op(OPC_RRCA,      8'h00, 8'h00, 8'h00);
    push_op(8'h10,         8'h12, 8'h34, 8'h56);
    push_op(OPC_LAST,      8'hFF, 8'hFF, 8'hFF);

    push_sp_write(16'h0000);
    for (int i = 0; i < 150; i++) push_instr(random_instr(15));
    // Let the pipeline empty completely before continuing.
    push_drain();
    for (int i = 0; i < 150; i++) push_instr(random_instr(15));
    push_sp_write(16'h8000);
    for (int i = 0; i < 140; i++) push_instr(random_instr(15));
    push_sp_write(16'($urandom_range(16'hFFFF)));
    for (int i = 0; i < 20; i++) push_instr(random_instr(15));
    push_sp_write(16'h0001);
    for (int i = 0; i < 20; i++) push_instr(random_instr(15));

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    while (program_queue.size() != 0 || in_bus.valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Executed %0d instructions, %0d of them unimplemented opcodes; checked %0d results.",
             items_accepted, unhandled_seen, beats_checked);
    $display("Stack pointer written %0d times between bursts of instructions.", sp_writes);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
